[hdl/hds_pkg.sv]
// Package of the heat diffusion stencil step: register codes, default sizes,
// fixed field widths and the control word passed into the update pipeline.
// No dependencies.
package hds_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;
    localparam int DEF_TEMP_BITS  = 16;

    // Fixed widths of the configuration registers.
    localparam int DIM_BITS       = 8;
    localparam int GAIN_BITS      = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;

    // Smallest grid edge and reset geometry.
    localparam int MIN_DIM = 2;
    localparam logic [DIM_BITS-1:0] RESET_DIM = DIM_BITS'(128);

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_GAIN_H      = 2'd2,
        REG_GAIN_V      = 2'd3
    } cfg_reg_t;

    // Control that travels with a stencil through the update pipeline.
    typedef struct packed {
        logic valid;
        logic frame_last;
    } hds_ctl_t;

endpackage

[hdl/hds_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Read-first: a read and write of the same entry in one cycle returns old data.
// No dependencies.
module hds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read share one clock edge.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/hds_update.sv]
// Arithmetic pipeline of the stencil: second differences, gain products,
// rounding, centre update, saturation and the output register.
// Depends on hds_pkg.
module hds_update #(
    parameter int TEMP_BITS = hds_pkg::DEF_TEMP_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  hds_pkg::hds_ctl_t                    in_ctl,
    input  logic signed [TEMP_BITS-1:0]          west,
    input  logic signed [TEMP_BITS-1:0]          east,
    input  logic signed [TEMP_BITS-1:0]          centre,
    input  logic signed [TEMP_BITS-1:0]          north,
    input  logic signed [TEMP_BITS-1:0]          south,
    input  logic [hds_pkg::GAIN_BITS-1:0]        gain_h,
    input  logic [hds_pkg::GAIN_BITS-1:0]        gain_v,
    output logic                                 advance,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [TEMP_BITS-1:0]          m_new_temp,
    output logic                                 m_saturated,
    output logic                                 m_frame_last
);
    import hds_pkg::*;

    localparam int DIFF_W  = TEMP_BITS + 2;
    localparam int PROD_W  = DIFF_W + GAIN_BITS + 1;
    localparam int SUM_W   = PROD_W + 1;
    localparam int DELTA_W = SUM_W - GAIN_BITS;
    localparam int VAL_W   = DELTA_W + 1;

    hds_ctl_t a_ctl_reg, b_ctl_reg, c_ctl_reg;
    logic signed [DIFF_W-1:0]    a_dh_reg, a_dv_reg;
    logic signed [TEMP_BITS-1:0] a_centre_reg, b_centre_reg, c_centre_reg;
    logic signed [PROD_W-1:0]    b_ph_reg, b_pv_reg;
    logic signed [DELTA_W-1:0]   c_delta_reg;

    logic                        out_valid_reg;
    logic signed [TEMP_BITS-1:0] out_temp_reg;
    logic                        out_sat_reg;
    logic                        out_last_reg;

    logic signed [DIFF_W-1:0]    w_x, e_x, c_x, n_x, s_x;
    logic signed [DIFF_W-1:0]    dh_next, dv_next;
    logic signed [GAIN_BITS:0]   gh_s, gv_s;
    logic signed [PROD_W-1:0]    ph_next, pv_next;
    logic [SUM_W-1:0]            sum_next;
    logic signed [VAL_W-1:0]     val;
    logic                        val_sat;
    logic signed [TEMP_BITS-1:0] temp_next;

    // The whole pipeline moves when the output word is empty or being taken.
    assign advance = !out_valid_reg || m_ready;

    // Second differences along both axes.
    always_comb begin
        w_x     = DIFF_W'(west);
        e_x     = DIFF_W'(east);
        c_x     = DIFF_W'(centre);
        n_x     = DIFF_W'(north);
        s_x     = DIFF_W'(south);
        dh_next = w_x + e_x - (c_x <<< 1);
        dv_next = n_x + s_x - (c_x <<< 1);
    end

    // Gains are unsigned, so they get a zero sign bit before the products.
    always_comb begin
        gh_s    = {1'b0, gain_h};
        gv_s    = {1'b0, gain_v};
        ph_next = PROD_W'(gh_s) * PROD_W'(a_dh_reg);
        pv_next = PROD_W'(gv_s) * PROD_W'(a_dv_reg);
    end

    // Sum the products and round half up to the temperature scale.
    assign sum_next = SUM_W'(b_ph_reg) + SUM_W'(b_pv_reg) + (SUM_W'(1) << (GAIN_BITS - 1));

    // Centre update and saturation to the signed temperature range.
    always_comb begin
        val       = VAL_W'(c_centre_reg) + VAL_W'(c_delta_reg);
        val_sat   = (val[VAL_W-1:TEMP_BITS-1] != '0) && (val[VAL_W-1:TEMP_BITS-1] != '1);
        temp_next = TEMP_BITS'(val);
        if (val_sat) begin
            temp_next = val[VAL_W-1] ? {1'b1, {(TEMP_BITS-1){1'b0}}}
                                     : {1'b0, {(TEMP_BITS-1){1'b1}}};
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_ctl_reg     <= '0;
            b_ctl_reg     <= '0;
            c_ctl_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            a_ctl_reg     <= in_ctl;
            b_ctl_reg     <= a_ctl_reg;
            c_ctl_reg     <= b_ctl_reg;
            out_valid_reg <= c_ctl_reg.valid;
        end
    end

    // Datapath registers of the stages.
    always_ff @(posedge aclk) begin
        if (advance) begin
            a_dh_reg     <= dh_next;
            a_dv_reg     <= dv_next;
            a_centre_reg <= centre;
            b_ph_reg     <= ph_next;
            b_pv_reg     <= pv_next;
            b_centre_reg <= a_centre_reg;
            c_delta_reg  <= signed'(sum_next[SUM_W-1:GAIN_BITS]);
            c_centre_reg <= b_centre_reg;
            out_temp_reg <= temp_next;
            out_sat_reg  <= val_sat;
            out_last_reg <= c_ctl_reg.frame_last;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_new_temp   = out_temp_reg;
    assign m_saturated  = out_sat_reg;
    assign m_frame_last = out_last_reg;

endmodule

[hdl/heat_diffusion_stencil_step.sv]
// Top level of the heat diffusion stencil step: counters, two line RAMs,
// the stencil window and the configuration registers.
// Depends on hds_pkg, hds_ram and hds_update.
//
// Usage: cells of a grid_width x grid_height frame enter on the s_ channel in
// raster order, one word per cell, followed by one row of padding words.
// Each accepted word from the second row on yields one result word on the m_
// channel: the updated temperature of the cell directly above it, with a
// clipping flag and a mark on the last cell of the frame. Words of the first
// row yield nothing. Neighbors outside the grid count as zero.
// Throughput is one word per cycle while results are taken; results pass the
// window, a, b, c and output registers. The rate is set by the two line RAMs,
// each read once and written once per word. When the receiver stalls, the
// pipeline and s_ready hold until the output word is taken. Reset clears the
// counters, the pipeline and the registers (geometry 128 x 128, gains zero);
// the RAMs need no clearing because no entry is read before it is written in
// the current frame. A write to a geometry register restarts the frame; the
// user must write configuration only idle, which the block does not enforce.
module heat_diffusion_stencil_step #(
    parameter int MAX_WIDTH  = hds_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hds_pkg::DEF_MAX_HEIGHT,
    parameter int TEMP_BITS  = hds_pkg::DEF_TEMP_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [TEMP_BITS-1:0]           s_cell_temp,
    input  logic                                  s_is_flush,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [TEMP_BITS-1:0]           m_new_temp,
    output logic                                  m_saturated,
    output logic                                  m_frame_last,
    input  logic                                  cfg_write,
    input  logic [hds_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [hds_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);
    import hds_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);

    logic [DIM_BITS-1:0]  grid_width_reg, grid_height_reg;
    logic [GAIN_BITS-1:0] gain_h_reg, gain_v_reg;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [WCNT_W-1:0]    eff_w;
    logic [ROW_W-1:0]     eff_h;

    logic                        advance, accept;
    logic                        col_last, geom_write;
    logic [COL_W-1:0]            rd_addr_a;
    logic signed [TEMP_BITS-1:0] south;
    logic [TEMP_BITS-1:0]        q_a, q_b;

    hds_ctl_t                    s1_ctl_reg, s1_ctl_next;
    logic signed [TEMP_BITS-1:0] s1_south_reg, ctr_reg, west_reg;
    logic                        s1_west_edge_reg, s1_east_edge_reg, s1_north_edge_reg;
    logic signed [TEMP_BITS-1:0] op_west, op_east, op_north;

    // Geometry in use, clamped to the supported range.
    always_comb begin
        if (int'(grid_width_reg) < MIN_DIM) begin
            eff_w = WCNT_W'(MIN_DIM);
        end else if (int'(grid_width_reg) > MAX_WIDTH) begin
            eff_w = WCNT_W'(MAX_WIDTH);
        end else begin
            eff_w = WCNT_W'(grid_width_reg);
        end
        if (int'(grid_height_reg) < MIN_DIM) begin
            eff_h = ROW_W'(MIN_DIM);
        end else if (int'(grid_height_reg) > MAX_HEIGHT) begin
            eff_h = ROW_W'(MAX_HEIGHT);
        end else begin
            eff_h = ROW_W'(grid_height_reg);
        end
    end

    // Handshake of the input channel follows the pipeline advance.
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    // Column and row position of the incoming word.
    always_comb begin
        col_last = (WCNT_W'(col_reg) + WCNT_W'(1)) == eff_w;
        col_next = col_reg + COL_W'(1);
        row_next = row_reg;
        if (col_last) begin
            col_next = '0;
            row_next = (row_reg == eff_h) ? '0 : row_reg + ROW_W'(1);
        end
    end

    // The padding row and flagged words enter the grid as zero.
    assign south = (row_reg == eff_h || s_is_flush) ? '0 : s_cell_temp;

    // The current-row RAM is read one column ahead; at the row end it wraps to
    // column zero, which already holds the first cell of the row just entered.
    assign rd_addr_a = col_last ? '0 : col_reg + COL_W'(1);

    assign geom_write = cfg_write && (cfg_index == REG_GRID_WIDTH
                                      || cfg_index == REG_GRID_HEIGHT);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= RESET_DIM;
            grid_height_reg <= RESET_DIM;
            gain_h_reg      <= '0;
            gain_v_reg      <= '0;
        end else if (cfg_write) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GRID_WIDTH:  grid_width_reg  <= DIM_BITS'(cfg_wdata);
                REG_GRID_HEIGHT: grid_height_reg <= DIM_BITS'(cfg_wdata);
                REG_GAIN_H:      gain_h_reg      <= GAIN_BITS'(cfg_wdata);
                REG_GAIN_V:      gain_v_reg      <= GAIN_BITS'(cfg_wdata);
            endcase
        end
    end

    // Position counters; a geometry write restarts the frame.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (geom_write) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Row being entered: one entry per column, written with the new cell.
    hds_ram #(
        .WIDTH(TEMP_BITS),
        .DEPTH(MAX_WIDTH)
    ) u_row_cur (
        .aclk (aclk),
        .we   (accept),
        .waddr(col_reg),
        .wdata(south),
        .re   (accept),
        .raddr(rd_addr_a),
        .rdata(q_a)
    );

    // Row two back: takes each centre as it passes and returns the north cell.
    hds_ram #(
        .WIDTH(TEMP_BITS),
        .DEPTH(MAX_WIDTH)
    ) u_row_old (
        .aclk (aclk),
        .we   (accept),
        .waddr(col_reg),
        .wdata(q_a),
        .re   (accept),
        .raddr(col_reg),
        .rdata(q_b)
    );

    // A result exists for every word after the first row.
    always_comb begin
        s1_ctl_next.valid      = accept && (row_reg != '0);
        s1_ctl_next.frame_last = (row_reg == eff_h) && col_last;
    end

    // Stencil window: the last RAM word becomes the centre, the centre the west.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg <= '0;
        end else if (advance) begin
            s1_ctl_reg <= s1_ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ctr_reg           <= signed'(q_a);
            west_reg          <= ctr_reg;
            s1_south_reg      <= south;
            s1_west_edge_reg  <= (col_reg == '0);
            s1_east_edge_reg  <= col_last;
            s1_north_edge_reg <= (row_reg == ROW_W'(1));
        end
    end

    // Neighbors outside the grid read as zero.
    assign op_west  = s1_west_edge_reg  ? '0 : west_reg;
    assign op_east  = s1_east_edge_reg  ? '0 : signed'(q_a);
    assign op_north = s1_north_edge_reg ? '0 : signed'(q_b);

    hds_update #(
        .TEMP_BITS(TEMP_BITS)
    ) u_update (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_ctl      (s1_ctl_reg),
        .west        (op_west),
        .east        (op_east),
        .centre      (ctr_reg),
        .north       (op_north),
        .south       (s1_south_reg),
        .gain_h      (gain_h_reg),
        .gain_v      (gain_v_reg),
        .advance     (advance),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_new_temp  (m_new_temp),
        .m_saturated (m_saturated),
        .m_frame_last(m_frame_last)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench of heat_diffusion_stencil_step: directed stencil rows and random
// frames of varying geometry and gain, checked against an in-file diffusion predictor.
// Depends on hds_pkg and the heat_diffusion_stencil_step RTL.
module testbench;
    import hds_pkg::*;

    localparam int MAX_WIDTH      = DEF_MAX_WIDTH;
    localparam int MAX_HEIGHT     = DEF_MAX_HEIGHT;
    localparam int TEMP_BITS      = DEF_TEMP_BITS;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 12;
    localparam int RANDOM_WORDS   = 1950;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLDOFF_AT     = 600;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int REPORT_LIMIT   = 10;
    localparam int DIRECTED_ROWS  = 28;

    typedef struct packed {
        logic signed [TEMP_BITS-1:0] new_temp;
        logic                        saturated;
        logic                        frame_last;
    } cell_result_t;

    typedef enum {ROW_WRITE, ROW_WORD} row_kind_t;
    typedef enum {CHECK_MODEL, CHECK_NONE, CHECK_GIVEN} check_t;
    typedef enum {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_PERIODIC} ready_mode_t;

    typedef struct {
        row_kind_t                   kind;
        cfg_reg_t                    index;
        logic [CFG_DATA_BITS-1:0]    data;
        logic signed [TEMP_BITS-1:0] temp;
        logic                        flush;
        check_t                      check;
        cell_result_t                given;
    } stim_row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [TEMP_BITS-1:0]   s_cell_temp;
    logic                          s_is_flush;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [TEMP_BITS-1:0]   m_new_temp;
    logic                          m_saturated;
    logic                          m_frame_last;
    logic                          cfg_write;
    logic [CFG_INDEX_BITS-1:0]     cfg_index;
    logic [CFG_DATA_BITS-1:0]      cfg_wdata;

    // Predictor state: configuration copy, the two-row window and the raster position.
    logic [DIM_BITS-1:0]  cfg_width  = RESET_DIM;
    logic [DIM_BITS-1:0]  cfg_height = RESET_DIM;
    logic [GAIN_BITS-1:0] gain_h     = '0;
    logic [GAIN_BITS-1:0] gain_v     = '0;
    int                   row_window [2*MAX_WIDTH+1];
    int                   cur_col    = 0;
    int                   cur_row    = 0;

    cell_result_t pending_updates [$];

    int  failures         = 0;
    int  results_checked  = 0;
    int  clipped_seen     = 0;
    int  frame_ends_seen  = 0;
    int  words_sent       = 0;
    int  random_words     = 0;
    int  settings_written = 0;
    int  idle_cycles      = 0;
    int  burst_left       = 0;
    bit  sender_gaps      = 1'b0;
    bit  holdoff_done     = 1'b0;

    // Directed rows: reset geometry, gains of zero (result equals the center), full gains
    // with extreme temperatures, clamped geometry, flush inside the frame and a padding
    // word with its flag clear.
    stim_row_t stim_rows [DIRECTED_ROWS] = '{
        '{ROW_WORD,  REG_GRID_WIDTH,  16'h0000, 16'sh7FFF, 1'b0, CHECK_NONE,  '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WORD,  REG_GRID_WIDTH,  16'h0000, 16'sh8000, 1'b0, CHECK_NONE,  '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WRITE, REG_GRID_WIDTH,  16'h0002, 16'sh0000, 1'b0, CHECK_NONE,  '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WRITE, REG_GRID_HEIGHT, 16'h0002, 16'sh0000, 1'b0, CHECK_NONE,  '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WORD,  REG_GRID_WIDTH,  16'h0000, 16'sh7FFF, 1'b0, CHECK_NONE,  '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WORD,  REG_GRID_WIDTH,  16'h0000, 16'sh8000, 1'b0, CHECK_NONE,  '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WORD,  REG_GRID_WIDTH,  16'h0000, 16'sh0001, 1'b0, CHECK_GIVEN,
            '{16'sh7FFF, 1'b0, 1'b0}},
        '{ROW_WORD,  REG_GRID_WIDTH,  16'h0000, 16'shFFFF, 1'b0, CHECK_GIVEN,
            '{16'sh8000, 1'b0, 1'b0}},
        '{ROW_WORD,  REG_GRID_WIDTH,  16'h0000, 16'sh0000, 1'b1, CHECK_GIVEN,
            '{16'sh0001, 1'b0, 1'b0}},
        '{ROW_WORD,  REG_GRID_WIDTH,  16'h0000, 16'sh0000, 1'b1, CHECK_GIVEN,
            '{16'shFFFF, 1'b0, 1'b1}},
        '{ROW_WRITE, REG_GAIN_H,      16'hFFFF, 16'sh0000, 1'b0, CHECK_NONE,  '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WRITE, REG_GAIN_V,      16'hFFFF, 16'sh0000, 1'b0, CHECK_NONE,  '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WORD,  REG_GRID_WIDTH,  16'h0000, 16'sh7FFF, 1'b0, CHECK_MODEL, '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WORD,  REG_GRID_WIDTH,  16'h0000, 16'sh8000, 1'b0, CHECK_MODEL, '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WORD,  REG_GRID_WIDTH,  16'h0000, 16'sh8000, 1'b0, CHECK_MODEL, '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WORD,  REG_GRID_WIDTH,  16'h0000, 16'sh7FFF, 1'b0, CHECK_MODEL, '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WORD,  REG_GRID_WIDTH,  16'h0000, 16'sh3039, 1'b0, CHECK_MODEL, '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WORD,  REG_GRID_WIDTH,  16'h0000, 16'shFFFF, 1'b1, CHECK_MODEL, '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WRITE, REG_GRID_WIDTH,  16'h0001, 16'sh0000, 1'b0, CHECK_NONE,  '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WRITE, REG_GRID_HEIGHT, 16'hFF00, 16'sh0000, 1'b0, CHECK_NONE,  '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WRITE, REG_GAIN_H,      16'h4000, 16'sh0000, 1'b0, CHECK_NONE,  '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WRITE, REG_GAIN_V,      16'h8000, 16'sh0000, 1'b0, CHECK_NONE,  '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WORD,  REG_GRID_WIDTH,  16'h0000, 16'sh03E8, 1'b0, CHECK_MODEL, '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WORD,  REG_GRID_WIDTH,  16'h0000, 16'sh7530, 1'b1, CHECK_MODEL, '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WORD,  REG_GRID_WIDTH,  16'h0000, 16'shEC78, 1'b0, CHECK_MODEL, '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WORD,  REG_GRID_WIDTH,  16'h0000, 16'sh0007, 1'b0, CHECK_MODEL, '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WORD,  REG_GRID_WIDTH,  16'h0000, 16'sh0000, 1'b1, CHECK_MODEL, '{16'sh0, 1'b0, 1'b0}},
        '{ROW_WORD,  REG_GRID_WIDTH,  16'h0000, 16'sh5555, 1'b1, CHECK_MODEL, '{16'sh0, 1'b0, 1'b0}}
    };

    heat_diffusion_stencil_step dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cell_temp  (s_cell_temp),
        .s_is_flush   (s_is_flush),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_new_temp   (m_new_temp),
        .m_saturated  (m_saturated),
        .m_frame_last (m_frame_last),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Geometry registers are clamped to the supported range.
    function automatic int eff_dim(int raw, int top);
        if (raw < MIN_DIM) return MIN_DIM;
        if (raw > top) return top;
        return raw;
    endfunction

    // A neighbor of the current frame; anything outside the grid reads as zero.
    function automatic longint cell_value(longint r, longint c, int w);
        if (r < 0 || c < 0 || c >= w) return 0;
        return longint'(row_window[int'((r * w + c) % (2 * w + 1))]);
    endfunction

    // Advances the raster position by one word and works out the update of the cell
    // one row above it, if there is one.
    task automatic diffuse_cell(input logic signed [TEMP_BITS-1:0] temp, input logic flush,
                                output bit produced, output cell_result_t res);
        int     w;
        int     h;
        int     col;
        int     row;
        longint south;
        longint centre;
        longint dh;
        longint dv;
        longint acc;
        longint val;
        longint hi;
        longint lo;
        w = eff_dim(int'(cfg_width), MAX_WIDTH);
        h = eff_dim(int'(cfg_height), MAX_HEIGHT);
        col = (cur_col >= w) ? 0 : cur_col;
        row = (cur_row > h) ? 0 : cur_row;
        hi = (64'sd1 <<< (TEMP_BITS - 1)) - 1;
        lo = -hi - 1;
        south = (row >= h || flush) ? 0 : longint'(temp);
        produced = (row > 0);
        res = '0;
        if (produced) begin
            centre = cell_value(row - 1, col, w);
            dh = cell_value(row - 1, col - 1, w) + cell_value(row - 1, col + 1, w) - 2 * centre;
            dv = cell_value(row - 2, col, w) + south - 2 * centre;
            acc = longint'(gain_h) * dh + longint'(gain_v) * dv;
            // Round away the 16 fraction bits of the Q0.16 gains by adding one half, then floor.
            val = centre + ((acc + 64'sd32768) >>> 16);
            if (val > hi) begin
                val = hi;
                res.saturated = 1'b1;
            end
            if (val < lo) begin
                val = lo;
                res.saturated = 1'b1;
            end
            res.new_temp = TEMP_BITS'(val);
            res.frame_last = (row == h && col == w - 1);
        end
        row_window[(row * w + col) % (2 * w + 1)] = int'(south);
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row > h) row = 0;
        end
        cur_col = col;
        cur_row = row;
    endtask

    task automatic record_failure(input string text);
        failures++;
        if (failures <= REPORT_LIMIT) $display("%s", text);
    endtask

    function automatic logic signed [TEMP_BITS-1:0] pick_temp();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return TEMP_BITS'(int'($urandom_range(0, 600)) - 300);
            default: return TEMP_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offers one word in the current burst, waits for its handshake and records what it
    // should produce. Called at a clock edge and returns at the accepting edge.
    task automatic send_word(input logic signed [TEMP_BITS-1:0] temp, input logic flush,
                             input check_t check, input cell_result_t given);
        bit           produced;
        cell_result_t predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (sender_gaps) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_cell_temp <= temp;
        s_is_flush  <= flush;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        diffuse_cell(temp, flush, produced, predicted);
        words_sent++;
        case (check)
            CHECK_MODEL: if (produced) pending_updates.push_back(predicted);
            CHECK_GIVEN: pending_updates.push_back(given);
            default: ;
        endcase
    endtask

    // Sends words that follow the raster position: grid words with the odd flush flag,
    // padding words with any flag and content. Stops once the random budget is spent.
    task automatic send_random_words(input int count);
        logic flush;
        repeat (count) begin
            if (random_words >= RANDOM_WORDS) break;
            if (cur_row >= eff_dim(int'(cfg_height), MAX_HEIGHT))
                flush = 1'($urandom_range(0, 1));
            else
                flush = ($urandom_range(0, 15) == 0);
            send_word(pick_temp(), flush, CHECK_MODEL, '0);
            random_words++;
        end
    endtask

    // Stops the sender, waits for every expected word and lets the pipeline empty.
    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes one register and mirrors it in the predictor.
    task automatic write_register(input cfg_reg_t index, input logic [CFG_DATA_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge aclk);
        case (index)
            REG_GRID_WIDTH: begin
                cfg_width = data[DIM_BITS-1:0];
                cur_col = 0;
                cur_row = 0;
            end
            REG_GRID_HEIGHT: begin
                cfg_height = data[DIM_BITS-1:0];
                cur_col = 0;
                cur_row = 0;
            end
            REG_GAIN_H: gain_h = data[GAIN_BITS-1:0];
            REG_GAIN_V: gain_v = data[GAIN_BITS-1:0];
            default: ;
        endcase
        settings_written++;
        cfg_write <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return CFG_DATA_BITS'($urandom_range(0, 65535));
            default: return CFG_DATA_BITS'($urandom_range(0, 16'h3000));
        endcase
    endfunction

    // Compare each accepted result word with the oldest expected update.
    always @(posedge aclk) begin
        cell_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_updates.size() == 0) begin
                record_failure($sformatf("unexpected result word: new_temp %0d sat %0b last %0b",
                                         m_new_temp, m_saturated, m_frame_last));
            end else begin
                want = pending_updates.pop_front();
                if (m_new_temp !== want.new_temp || m_saturated !== want.saturated ||
                    m_frame_last !== want.frame_last)
                    record_failure($sformatf(
                        "result %0d (expected/actual): temp %0d/%0d, sat %0b/%0b, last %0b/%0b",
                        results_checked, want.new_temp, m_new_temp, want.saturated, m_saturated,
                        want.frame_last, m_frame_last));
                if (want.saturated) clipped_seen++;
                if (want.frame_last) frame_ends_seen++;
            end
            results_checked++;
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: changing stall patterns, plus one long hold-off to back up the pipeline.
    initial begin
        ready_mode_t mode;
        int          mode_left;
        int          phase_tick;
        mode = READY_ALWAYS;
        mode_left = 0;
        phase_tick = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (!holdoff_done && results_checked >= HOLDOFF_AT) begin
                holdoff_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES - 1) @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode = ready_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(50, 200);
                end
                mode_left--;
                phase_tick++;
                case (mode)
                    READY_ALWAYS:   m_ready <= 1'b1;
                    READY_COIN:     m_ready <= 1'($urandom_range(0, 1));
                    READY_MOSTLY:   m_ready <= ($urandom_range(0, 9) != 0);
                    READY_PERIODIC: m_ready <= (phase_tick % 3 != 0);
                    default:        m_ready <= 1'b1;
                endcase
            end
        end
    end

    // Sender: reset, the directed rows, then random phases of frames.
    initial begin
        int                       phase;
        int                       w;
        int                       h;
        logic [DIM_BITS-1:0]      width_raw;
        logic [DIM_BITS-1:0]      height_raw;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_cell_temp = '0;
        s_is_flush  = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = REG_GRID_WIDTH;
        cfg_wdata   = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_WRITE) begin
                drain_and_settle();
                write_register(stim_rows[i].index, stim_rows[i].data);
            end else begin
                send_word(stim_rows[i].temp, stim_rows[i].flush, stim_rows[i].check,
                          stim_rows[i].given);
            end
        end

        phase = 0;
        while (random_words < RANDOM_WORDS) begin
            drain_and_settle();
            sender_gaps = ($urandom_range(0, 3) != 0);
            if (phase >= 3 && $urandom_range(0, 2) == 0) begin
                // New gains only; the frame in progress carries on where it stopped.
                write_register(REG_GAIN_H, pick_gain());
                write_register(REG_GAIN_V, pick_gain());
                w = eff_dim(int'(cfg_width), MAX_WIDTH);
                h = eff_dim(int'(cfg_height), MAX_HEIGHT);
                if (cur_row != 0 || cur_col != 0)
                    send_random_words(w * (h + 1) - (cur_row * w + cur_col));
            end else begin
                case (phase)
                    0: begin
                        width_raw = 8'd128;
                        height_raw = 8'd1;
                    end
                    1: begin
                        width_raw = 8'd2;
                        height_raw = 8'd200;
                    end
                    2: begin
                        width_raw = 8'd255;
                        height_raw = 8'd2;
                    end
                    default: begin
                        width_raw = ($urandom_range(0, 9) == 0) ?
                            DIM_BITS'($urandom_range(0, 1)) : DIM_BITS'($urandom_range(2, 9));
                        height_raw = ($urandom_range(0, 9) == 0) ?
                            DIM_BITS'($urandom_range(0, 1)) : DIM_BITS'($urandom_range(2, 8));
                    end
                endcase
                write_register(REG_GRID_WIDTH, {8'($urandom_range(0, 255)), width_raw});
                write_register(REG_GRID_HEIGHT, {8'($urandom_range(0, 255)), height_raw});
                write_register(REG_GAIN_H, pick_gain());
                write_register(REG_GAIN_V, pick_gain());
            end
            w = eff_dim(int'(cfg_width), MAX_WIDTH);
            h = eff_dim(int'(cfg_height), MAX_HEIGHT);
            send_random_words(((phase < 3) ? 1 : $urandom_range(1, 4)) * w * (h + 1));
            // Now and then stop partway into a frame.
            if (phase >= 3 && $urandom_range(0, 2) == 0)
                send_random_words($urandom_range(1, w * h));
            phase++;
        end

        drain_and_settle();
        $display("Covered %0d words in %0d phases with %0d register writes.",
                 words_sent, phase, settings_written);
        $display("Compared %0d results: %0d clipped, %0d frame ends, receiver hold-off %0s.",
                 results_checked, clipped_seen, frame_ends_seen, holdoff_done ? "done" : "missed");
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
hdl/hds_pkg.sv
hdl/hds_ram.sv
hdl/hds_update.sv
hdl/heat_diffusion_stencil_step.sv
tb/testbench.sv
